### hdl/grfs_pkg.sv
// Shared types and constants for the grid rectangle fill store.
`default_nettype none
package grfs_pkg;

    // Command codes on the input port
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_FILL = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;

    localparam int COORD_W   = 6;
    localparam int COORD_MAX = 64;   // coordinates reach 63 at most
    localparam int CFG_W     = 7;
    localparam int WORD_W    = 32;
    localparam int FIFO_DEPTH = 2;

    // Classified operation handed from the front to the back
    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_FILL,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic                       oor;
        logic [COORD_W-1:0]         r0;
        logic [COORD_W-1:0]         c0;
        logic [COORD_W-1:0]         r1;
        logic [COORD_W-1:0]         c1;
        logic signed [WORD_W-1:0]   value;
    } t_item;

endpackage
`default_nettype wire

### hdl/grid_rectangle_fill_store.sv
// Top level of the grid rectangle fill store.
`default_nettype none
// Grid store of 32-bit signed cells, MAX_ROWS x MAX_COLS (coordinates are
// 6 bits, so at most 64 x 64 cells are reachable). A command is taken when
// i_start is high and o_busy is low; every command yields exactly one result
// beat, flagged by o_done for one cycle. The receiver cannot stall: results
// are dropped if not sampled on that cycle. Commands: load one cell, fill an
// inclusive rectangle, read one cell. A coordinate at or past the rows/cols in
// use (or past the grid size) sets o_out_of_range and the command does nothing;
// an empty rectangle writes nothing. Reading a never-written cell returns
// undefined data. The grid is stored as one RAM lane per column, one
// row per address, so a fill writes one full row segment per cycle, from the
// first row to the last; a read goes through the registered RAM read port.
// A two-entry command queue sits between the checker front and the executing
// back, so o_busy is high only while that queue is full. Config writes
// (i_cfg_*) are always ready and must be issued only while the block is idle.
// No clearing pass after reset.
module grid_rectangle_fill_store #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [1:0]                         i_cfg_index,
    input  wire logic [grfs_pkg::CFG_W-1:0]         i_cfg_data,
    // command channel
    input  wire logic                               i_start,
    output logic                                    o_busy,
    input  wire logic [1:0]                         i_cmd,
    input  wire logic [grfs_pkg::COORD_W-1:0]       i_first_row,
    input  wire logic [grfs_pkg::COORD_W-1:0]       i_first_col,
    input  wire logic [grfs_pkg::COORD_W-1:0]       i_last_row,
    input  wire logic [grfs_pkg::COORD_W-1:0]       i_last_col,
    input  wire logic signed [grfs_pkg::WORD_W-1:0] i_value,
    // result beat
    output logic                                    o_done,
    output logic signed [grfs_pkg::WORD_W-1:0]      o_read_value,
    output logic                                    o_out_of_range
);

    grfs_pkg::t_item push_item;
    grfs_pkg::t_item head_item;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    // busy only when the queue cannot take another command
    assign o_busy = full;

    grfs_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .i_first_row (i_first_row),
        .i_first_col (i_first_col),
        .i_last_row  (i_last_row),
        .i_last_col  (i_last_col),
        .i_value     (i_value),
        .i_full      (full),
        .o_push      (push),
        .o_item      (push_item)
    );

    grfs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (empty)
    );

    grfs_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (head_item),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_done         (o_done),
        .o_read_value   (o_read_value),
        .o_out_of_range (o_out_of_range)
    );

endmodule
`default_nettype wire

### hdl/grfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module grfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/grfs_fifo.sv
// Short command queue between the front and the back.
`default_nettype none
module grfs_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire grfs_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output grfs_pkg::t_item     o_item,
    output logic                o_empty
);

    localparam int PTR_W = (grfs_pkg::FIFO_DEPTH > 1) ? $clog2(grfs_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(grfs_pkg::FIFO_DEPTH + 1);

    grfs_pkg::t_item    r_mem [grfs_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(grfs_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(grfs_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(grfs_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

### hdl/grfs_front.sv
// Command front end: config registers, range checks and classification.
`default_nettype none
module grfs_front #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [1:0]                         i_cfg_index,
    input  wire logic [grfs_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                               i_start,
    input  wire logic [1:0]                         i_cmd,
    input  wire logic [grfs_pkg::COORD_W-1:0]       i_first_row,
    input  wire logic [grfs_pkg::COORD_W-1:0]       i_first_col,
    input  wire logic [grfs_pkg::COORD_W-1:0]       i_last_row,
    input  wire logic [grfs_pkg::COORD_W-1:0]       i_last_col,
    input  wire logic signed [grfs_pkg::WORD_W-1:0] i_value,
    input  wire logic                               i_full,
    output logic                                    o_push,
    output grfs_pkg::t_item                         o_item
);

    localparam int LIM_W = 11;   // wide enough for MAX_ROWS/MAX_COLS values up to 2047

    logic [grfs_pkg::CFG_W-1:0] r_rows;
    logic [grfs_pkg::CFG_W-1:0] r_cols;
    logic                       r0_ok, c0_ok, r1_ok, c1_ok;
    logic                       empty_rect;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= grfs_pkg::CFG_W'(grfs_pkg::COORD_MAX);
            r_cols <= grfs_pkg::CFG_W'(grfs_pkg::COORD_MAX);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                grfs_pkg::REG_ROWS: r_rows <= i_cfg_data;
                grfs_pkg::REG_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // in range means below both the register and the grid size
    assign r0_ok = ({1'b0, i_first_row} < r_rows)
                && (LIM_W'(i_first_row) < LIM_W'(MAX_ROWS));
    assign c0_ok = ({1'b0, i_first_col} < r_cols)
                && (LIM_W'(i_first_col) < LIM_W'(MAX_COLS));
    assign r1_ok = ({1'b0, i_last_row} < r_rows)
                && (LIM_W'(i_last_row) < LIM_W'(MAX_ROWS));
    assign c1_ok = ({1'b0, i_last_col} < r_cols)
                && (LIM_W'(i_last_col) < LIM_W'(MAX_COLS));
    assign empty_rect = (i_first_row > i_last_row) || (i_first_col > i_last_col);

    assign o_push = i_start && !i_full;

    always_comb begin
        o_item       = '0;
        o_item.r0    = i_first_row;
        o_item.c0    = i_first_col;
        o_item.r1    = i_last_row;
        o_item.c1    = i_last_col;
        o_item.value = i_value;
        o_item.op    = grfs_pkg::OP_NOP;
        o_item.oor   = 1'b0;
        case (i_cmd)
            grfs_pkg::CMD_LOAD: begin
                if (r0_ok && c0_ok) o_item.op = grfs_pkg::OP_LOAD;
                else                o_item.oor = 1'b1;
            end
            grfs_pkg::CMD_READ: begin
                if (r0_ok && c0_ok) o_item.op = grfs_pkg::OP_READ;
                else                o_item.oor = 1'b1;
            end
            grfs_pkg::CMD_FILL: begin
                if (!(r0_ok && c0_ok && r1_ok && c1_ok)) o_item.oor = 1'b1;
                else if (!empty_rect)                     o_item.op  = grfs_pkg::OP_FILL;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### hdl/grfs_back.sv
// Command back end: column-lane grid memory, fill sequencer and result register.
`default_nettype none
module grfs_back #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire grfs_pkg::t_item            i_item,
    input  wire logic                       i_empty,
    output logic                            o_pop,
    output logic                            o_done,
    output logic signed [grfs_pkg::WORD_W-1:0] o_read_value,
    output logic                            o_out_of_range
);

    // Only the first 64 rows and columns are reachable by a 6-bit coordinate
    localparam int ROWS_D = (MAX_ROWS < grfs_pkg::COORD_MAX) ? MAX_ROWS : grfs_pkg::COORD_MAX;
    localparam int LANES  = (MAX_COLS < grfs_pkg::COORD_MAX) ? MAX_COLS : grfs_pkg::COORD_MAX;
    localparam int ROW_W  = (ROWS_D > 1) ? $clog2(ROWS_D) : 1;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW     = grfs_pkg::COORD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_READ
    } t_state;

    t_state                         r_state;
    logic [CW-1:0]                  r_row;
    logic [CW-1:0]                  r_last;
    logic [CW-1:0]                  r_c_lo;
    logic [CW-1:0]                  r_c_hi;
    logic [CW-1:0]                  r_col;
    logic signed [grfs_pkg::WORD_W-1:0] r_value;
    logic                           r_done;
    logic signed [grfs_pkg::WORD_W-1:0] r_read_value;
    logic                           r_oor;

    logic                           can_pop;
    logic                           we;
    logic [CW-1:0]                  w_row;
    logic [CW-1:0]                  w_c_lo;
    logic [CW-1:0]                  w_c_hi;
    logic [grfs_pkg::WORD_W-1:0]    w_data;
    logic [grfs_pkg::WORD_W-1:0]    lane_q [LANES];

    assign can_pop = (r_state == S_IDLE) && !i_empty;
    assign o_pop   = can_pop;

    // write port: first row straight from the queue head, later rows from the sequencer
    always_comb begin
        we     = 1'b0;
        w_row  = i_item.r0;
        w_c_lo = i_item.c0;
        w_c_hi = i_item.c1;
        w_data = i_item.value;
        if (r_state == S_FILL) begin
            we     = 1'b1;
            w_row  = r_row;
            w_c_lo = r_c_lo;
            w_c_hi = r_c_hi;
            w_data = r_value;
        end else if (can_pop) begin
            case (i_item.op)
                grfs_pkg::OP_LOAD: begin
                    we     = 1'b1;
                    w_c_hi = i_item.c0;
                end
                grfs_pkg::OP_FILL: we = 1'b1;
                default:           we = 1'b0;
            endcase
        end
    end

    // one RAM lane per column; a row write enables the lanes inside the column span
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        localparam logic [CW-1:0] LANE_IDX = CW'(l);
        logic lane_we;
        assign lane_we = we && (LANE_IDX >= w_c_lo) && (LANE_IDX <= w_c_hi);
        grfs_ram #(
            .WIDTH (grfs_pkg::WORD_W),
            .DEPTH (ROWS_D)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (lane_we),
            .i_waddr (w_row[ROW_W-1:0]),
            .i_wdata (w_data),
            .i_raddr (i_item.r0[ROW_W-1:0]),
            .o_rdata (lane_q[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (can_pop) begin
                        r_read_value <= '0;
                        r_oor        <= 1'b0;
                        case (i_item.op)
                            grfs_pkg::OP_NOP: begin
                                r_done <= 1'b1;
                                r_oor  <= i_item.oor;
                            end
                            grfs_pkg::OP_LOAD: r_done <= 1'b1;
                            grfs_pkg::OP_FILL: begin
                                if (i_item.r0 == i_item.r1) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_state <= S_FILL;
                                    r_row   <= i_item.r0 + 1'b1;
                                    r_last  <= i_item.r1;
                                    r_c_lo  <= i_item.c0;
                                    r_c_hi  <= i_item.c1;
                                    r_value <= i_item.value;
                                end
                            end
                            grfs_pkg::OP_READ: begin
                                r_state <= S_READ;
                                r_col   <= i_item.c0;
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                S_FILL: begin
                    if (r_row == r_last) begin
                        r_done       <= 1'b1;
                        r_read_value <= '0;
                        r_oor        <= 1'b0;
                        r_state      <= S_IDLE;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                S_READ: begin
                    r_done       <= 1'b1;
                    r_read_value <= lane_q[r_col[LANE_W-1:0]];
                    r_oor        <= 1'b0;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_read_value   = r_read_value;
    assign o_out_of_range = r_oor;

endmodule
`default_nettype wire
